[hw/rtl/amic_pkg.sv]
// Shared constants and types for the amicable pair checker.
`timescale 1ns / 1ps

package amic_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PAIR,
        ST_ACCUM,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

endpackage

[hw/rtl/amic_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module amic_divider
    import amic_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_req_t              req,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output div_rsp_t              rsp,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   trial;

    assign shifted = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign trial   = shifted - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CNT_BITS'(VALUE_BITS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[VALUE_BITS])
            begin
                rem_next = trial[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/amicable_pair_check.sv]
// Top level: sequencer over a shared divider for the amicable pair test.
// For each of the two values n the block tries max(1, floor(sqrt(n))) trial divisors;
// each trial is one division on the shared divider plus the DIV_START and DIV_WAIT
// sequencer steps, and each divisor hit adds the PAIR and ACCUM steps.
// Throughput: one word at a time; the next word can be accepted in the cycle done pulses.
// Result shows for one cycle on done; the receiver cannot stall. rst_n is async, active low.
`timescale 1ns / 1ps

module amicable_pair_check
    import amic_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] first_value,
    input  logic [VALUE_BITS-1:0] second_value,
    output logic                  done,
    output logic                  is_amicable
);

    state_t state_reg, state_next;

    logic                  sel_reg, sel_next;
    logic [VALUE_BITS-1:0] a_reg, a_next;
    logic [VALUE_BITS-1:0] b_reg, b_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [VALUE_BITS-1:0] i_reg, i_next;
    logic [VALUE_BITS:0]   add_reg, add_next;
    logic [VALUE_BITS-1:0] sum_reg, sum_next;
    logic                  over_reg, over_next;
    logic [VALUE_BITS-1:0] sum_a_reg, sum_a_next;
    logic                  over_a_reg, over_a_next;
    logic                  done_reg, done_next;
    logic                  amic_reg, amic_next;

    div_req_t              div_req;
    div_rsp_t              div_rsp;
    logic [VALUE_BITS-1:0] quo;
    logic [VALUE_BITS-1:0] rem;
    logic [VALUE_BITS+1:0] total;
    logic                  trial_end;

    amic_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (n_reg),
        .divisor   (i_reg),
        .rsp       (div_rsp),
        .quotient  (quo),
        .remainder (rem)
    );

    assign trial_end = i_reg > quo;
    assign total     = {2'b00, sum_reg} + {1'b0, add_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_DIV_START;
            ST_DIV_START:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_rsp.done)
                begin
                    if (trial_end)
                        state_next = sel_reg ? ST_REPORT : ST_DIV_START;
                    else if (rem == '0)
                        state_next = ST_PAIR;
                    else
                        state_next = ST_DIV_START;
                end
            ST_PAIR:
                state_next = ST_ACCUM;
            ST_ACCUM:
                state_next = ST_DIV_START;
            ST_REPORT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        div_req.start = 1'b0;
        busy          = 1'b1;
        unique case (state_reg)
            ST_IDLE:      busy = 1'b0;
            ST_DIV_START: div_req.start = 1'b1;
            default:      busy = 1'b1;
        endcase
    end

    // datapath
    always_comb
    begin
        sel_next    = sel_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        add_next    = add_reg;
        sum_next    = sum_reg;
        over_next   = over_reg;
        sum_a_next  = sum_a_reg;
        over_a_next = over_a_reg;
        done_next   = 1'b0;
        amic_next   = amic_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    a_next    = first_value;
                    b_next    = second_value;
                    n_next    = first_value;
                    sel_next  = 1'b0;
                    i_next    = VALUE_BITS'(2);
                    sum_next  = VALUE_BITS'(1);
                    over_next = 1'b0;
                end
            ST_DIV_WAIT:
                if (div_rsp.done)
                begin
                    if (trial_end)
                    begin
                        if (!sel_reg)
                        begin
                            sum_a_next  = sum_reg;
                            over_a_next = over_reg;
                            sel_next    = 1'b1;
                            n_next      = b_reg;
                            i_next      = VALUE_BITS'(2);
                            sum_next    = VALUE_BITS'(1);
                            over_next   = 1'b0;
                        end
                    end
                    else if (rem != '0)
                        i_next = i_reg + 1'b1;
                end
            ST_PAIR:
                if (quo != i_reg)
                    add_next = {1'b0, i_reg} + {1'b0, quo};
                else
                    add_next = {1'b0, i_reg};
            ST_ACCUM:
            begin
                if (over_reg || (total[VALUE_BITS+1:VALUE_BITS] != 2'b00))
                begin
                    over_next = 1'b1;
                    sum_next  = '1;
                end
                else
                    sum_next = total[VALUE_BITS-1:0];
                i_next = i_reg + 1'b1;
            end
            ST_REPORT:
            begin
                amic_next = !over_a_reg && !over_reg
                            && (sum_a_reg == b_reg) && (sum_reg == a_reg);
                done_next = 1'b1;
            end
            default:
                done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        n_reg      <= n_next;
        i_reg      <= i_next;
        add_reg    <= add_next;
        sum_reg    <= sum_next;
        over_reg   <= over_next;
        sum_a_reg  <= sum_a_next;
        over_a_reg <= over_a_next;
        amic_reg   <= amic_next;
    end

    assign done        = done_reg;
    assign is_amicable = amic_reg;

endmodule

[hw/rtl/amic_checker.sv]
// Port-level checker for the amicable pair checker, bound to the top level.
`timescale 1ns / 1ps

module amic_checker
    import amic_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [VALUE_BITS-1:0] first_value,
    input logic [VALUE_BITS-1:0] second_value,
    input logic                  done,
    input logic                  is_amicable
);

    // accepted word keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("busy not raised after accept");

    // busy drops exactly when a result is shown
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy) && !$past(done)))
        else $error("result while busy, repeated or without a word in flight");

    a_word_known: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !$isunknown({first_value, second_value}))
        else $error("accepted word has unknown bits");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(is_amicable))
        else $error("result has unknown bits");

endmodule

bind amicable_pair_check amic_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_amic_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .first_value  (first_value),
    .second_value (second_value),
    .done         (done),
    .is_amicable  (is_amicable)
);

[tb/amicable_verdict_check.sv]
// Checker for amicable_pair_check: predicts each verdict and compares it with the block's result.
`timescale 1ns / 1ps

module amicable_verdict_check
    import amic_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [VALUE_BITS-1:0] first_value,
    input  logic [VALUE_BITS-1:0] second_value,
    input  logic                  done,
    input  logic                  is_amicable,
    output int                    error_count,
    output int                    pending,
    output int                    checked,
    output int                    hits
);

    localparam logic [VALUE_BITS+1:0] VALUE_MAX = {2'b00, {VALUE_BITS{1'b1}}};

    typedef struct packed {
        logic [VALUE_BITS-1:0] a;
        logic [VALUE_BITS-1:0] b;
        logic                  verdict;
    } pair_verdict_t;

    pair_verdict_t verdict_q[$];
    pair_verdict_t oldest;
    int            errs = 0;
    int            words_done = 0;
    int            amicable_seen = 0;

    // Sum of proper divisors (taken as 1 for n of 0 or 1); wide is set when it no longer fits in VALUE_BITS.
    function automatic logic [VALUE_BITS-1:0] aliquot_sum(input logic [VALUE_BITS-1:0] n,
                                                           output logic wide);
        logic [VALUE_BITS+1:0] acc;
        logic [VALUE_BITS+1:0] add;
        logic [VALUE_BITS-1:0] i;
        logic [VALUE_BITS-1:0] q;
        acc  = 1;
        wide = 1'b0;
        for (i = 2; i <= n / i; i++)
        begin
            q = n / i;
            if (n % i == 0)
            begin
                add = i;
                if (q != i)
                    add = add + q;
                if (!wide)
                begin
                    acc = acc + add;
                    if (acc > VALUE_MAX)
                        wide = 1'b1;
                end
            end
        end
        return acc[VALUE_BITS-1:0];
    endfunction

    function automatic logic predict_amicable(input logic [VALUE_BITS-1:0] a,
                                              input logic [VALUE_BITS-1:0] b);
        logic                  wide_a;
        logic                  wide_b;
        logic [VALUE_BITS-1:0] sum_a;
        logic [VALUE_BITS-1:0] sum_b;
        sum_a = aliquot_sum(a, wide_a);
        sum_b = aliquot_sum(b, wide_b);
        return !wide_a && !wide_b && sum_a == b && sum_b == a;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                verdict_q.push_back('{a: first_value, b: second_value,
                                      verdict: predict_amicable(first_value, second_value)});
            if (done)
            begin
                if (verdict_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result word: is_amicable=%0b", is_amicable);
                end
                else
                begin
                    oldest = verdict_q.pop_front();
                    words_done++;
                    if (is_amicable === 1'b1)
                        amicable_seen++;
                    if (is_amicable !== oldest.verdict)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("mismatch word %0d: a=%0d b=%0d expected %0b got %0b",
                                     words_done, oldest.a, oldest.b, oldest.verdict,
                                     is_amicable);
                    end
                end
            end
        end
        error_count <= errs;
        pending     <= verdict_q.size();
        checked     <= words_done;
        hits        <= amicable_seen;
    end

endmodule

[tb/tb_top.sv]
// Testbench top for amicable_pair_check: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
    import amic_pkg::*;

    localparam int VALUE_BITS  = VALUE_BITS_DEFAULT;
    localparam int IDLE_LIMIT  = 25_000_000;
    localparam int RANDOM_WORDS = 100;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [VALUE_BITS-1:0] first_value = '0;
    logic [VALUE_BITS-1:0] second_value = '0;
    logic                  busy;
    logic                  done;
    logic                  is_amicable;

    int error_count;
    int pending;
    int checked;
    int hits;
    int idle_cycles = 0;
    int burst_left = 0;

    logic [VALUE_BITS-1:0] op_a;
    logic [VALUE_BITS-1:0] op_b;
    logic [VALUE_BITS-1:0] tmp;
    int                    roll;
    int                    width_a;
    int                    width_b;

    amicable_pair_check #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .first_value(first_value),
        .second_value(second_value),
        .done(done),
        .is_amicable(is_amicable)
    );

    amicable_verdict_check #(
        .VALUE_BITS(VALUE_BITS)
    ) u_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .first_value(first_value),
        .second_value(second_value),
        .done(done),
        .is_amicable(is_amicable),
        .error_count(error_count),
        .pending(pending),
        .checked(checked),
        .hits(hits)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Amicable and perfect pairs (0..13), then pairs where only sum(a) == b holds (14..19).
    task automatic friendly_pair(input int k, output logic [VALUE_BITS-1:0] a,
                                 output logic [VALUE_BITS-1:0] b);
        case (k)
            0:       begin a = 220;   b = 284;   end
            1:       begin a = 1184;  b = 1210;  end
            2:       begin a = 2620;  b = 2924;  end
            3:       begin a = 5020;  b = 5564;  end
            4:       begin a = 6232;  b = 6368;  end
            5:       begin a = 10744; b = 10856; end
            6:       begin a = 12285; b = 14595; end
            7:       begin a = 17296; b = 18416; end
            8:       begin a = 63020; b = 76084; end
            9:       begin a = 66928; b = 66992; end
            10:      begin a = 6;     b = 6;     end
            11:      begin a = 28;    b = 28;    end
            12:      begin a = 496;   b = 496;   end
            13:      begin a = 8128;  b = 8128;  end
            14:      begin a = 12;    b = 16;    end
            15:      begin a = 18;    b = 21;    end
            16:      begin a = 20;    b = 22;    end
            17:      begin a = 24;    b = 36;    end
            18:      begin a = 25;    b = 6;     end
            default: begin a = 9;     b = 4;     end
        endcase
    endtask

    // Sends one word; bursts of back-to-back words alternate with idle gaps of junk data.
    task automatic issue(input logic [VALUE_BITS-1:0] a, input logic [VALUE_BITS-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 30);
            repeat (gap)
            begin
                start        <= 1'b0;
                first_value  <= $urandom;
                second_value <= $urandom;
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        start        <= 1'b1;
        first_value  <= a;
        second_value <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(0, 0);
        issue(1, 1);
        issue(0, 1);
        issue(1, 0);
        issue(6, 6);
        issue(28, 28);
        issue(496, 496);
        issue(8128, 8128);
        issue(220, 284);
        issue(284, 220);
        issue(220, 220);
        issue(1184, 1210);
        issue(9, 4);
        issue(4, 4);
        issue(12, 16);
        issue(7, 1);
        issue(17296, 18416);
        issue(12285, 14595);
        issue(66928, 66992);
        issue(9363584, 9437056);
        // abundant enough that its divisor sum leaves the value width
        issue({2'b11, {(VALUE_BITS-2){1'b0}}}, 0);
        issue('1, '1);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                friendly_pair($urandom_range(0, 13), op_a, op_b);
            else if (roll < 45)
            begin
                friendly_pair($urandom_range(0, 13), op_a, op_b);
                case ($urandom_range(0, 2))
                    0:       op_a = op_a + 1;
                    1:       op_b = op_b - 1;
                    default: op_b = op_b ^ (1 << $urandom_range(0, 6));
                endcase
            end
            else if (roll < 55)
                friendly_pair($urandom_range(14, 19), op_a, op_b);
            else
            begin
                width_a = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 17)
                                                      : $urandom_range(1, 12);
                width_b = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 17)
                                                      : $urandom_range(1, 12);
                op_a = $urandom & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - width_a));
                op_b = $urandom & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - width_b));
                if ($urandom_range(0, 7) == 0)
                    op_b = op_a;
            end
            if ($urandom_range(0, 1) == 1)
            begin
                tmp  = op_a;
                op_a = op_b;
                op_b = tmp;
            end
            issue(op_a, op_b);
        end
        start <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("checked %0d words: zero/one, perfect, amicable, near-miss and random pairs",
                 checked);
        $display("%0d amicable verdicts; extremes included all-ones and divisor-sum overflow",
                 hits);
        if (error_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
